/* hw/rtl/rpn_pkg.sv */
// Shared types and constants for the RPN stack calculator.
package rpn_pkg;

	localparam int DATA_W   = 32;
	localparam int ACT_W    = 3;
	localparam int STAT_W   = 2;
	localparam int DEPTH_W  = 5;
	localparam int DIV_STEP_W = $clog2(DATA_W);

	typedef logic [ACT_W-1:0]   action_t;
	typedef logic [STAT_W-1:0]  status_t;
	typedef logic [DATA_W-1:0]  data_t;
	typedef logic [DEPTH_W-1:0] depth_t;

	localparam action_t ACT_PUSH = 3'd0;
	localparam action_t ACT_ADD  = 3'd1;
	localparam action_t ACT_SUB  = 3'd2;
	localparam action_t ACT_MUL  = 3'd3;
	localparam action_t ACT_DIV  = 3'd4;
	localparam action_t ACT_POP  = 3'd5;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_FEW     = 2'd1;
	localparam status_t ST_FULL    = 2'd2;
	localparam status_t ST_DIVZERO = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic read;
		logic div_start;
		logic commit;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_div;
		logic div_done;
		logic out_free;
	} dp_stat_t;

endpackage

/* hw/rtl/rpn_item_if.sv */
// Input channel: one calculator action per word.
interface rpn_item_if;
	import rpn_pkg::*;

	logic               valid;
	logic               ready;
	action_t            action;
	logic signed [DATA_W-1:0] operand;

	modport source (output valid, action, operand, input ready);
	modport sink   (input valid, action, operand, output ready);
endinterface

/* hw/rtl/rpn_result_if.sv */
// Output channel: one result word per action.
interface rpn_result_if;
	import rpn_pkg::*;

	logic               valid;
	logic               ready;
	logic signed [DATA_W-1:0] result_value;
	depth_t             stack_depth;
	status_t            status;

	modport source (output valid, result_value, stack_depth, status, input ready);
	modport sink   (input valid, result_value, stack_depth, status, output ready);
endinterface

/* hw/rtl/rpn_div.sv */
// Iterative signed divider, truncating toward zero, one quotient bit per cycle.
module rpn_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  rpn_pkg::data_t dividend,
	input  rpn_pkg::data_t divisor,
	output rpn_pkg::data_t quotient,
	output logic          done
);
	import rpn_pkg::*;

	data_t                 quo_q;
	data_t                 rem_q;
	data_t                 mb_q;
	logic                  neg_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIV_STEP_W-1:0] step_q;

	logic [DATA_W:0] shifted;
	logic [DATA_W:0] diff;
	data_t           ma;
	data_t           mb;

	assign ma = dividend[DATA_W-1] ? (data_t'(0) - dividend) : dividend;
	assign mb = divisor[DATA_W-1] ? (data_t'(0) - divisor) : divisor;

	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, mb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= DIV_STEP_W'(DATA_W - 1);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= ma;
			rem_q <= '0;
			mb_q  <= mb;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q) begin
			// restoring step: keep the trial difference when it did not borrow
			rem_q <= diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], ~diff[DATA_W]};
		end
	end

	assign quotient = neg_q ? (data_t'(0) - quo_q) : quo_q;
	assign done     = done_q;

endmodule

/* hw/rtl/rpn_dp.sv */
// Datapath: operand stack memory, entry count, ALU, divider and result register.
module rpn_dp #(
	parameter int STACK_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rpn_pkg::dp_cmd_t  cmd,
	output rpn_pkg::dp_stat_t stat,
	input  rpn_pkg::action_t  item_action,
	input  rpn_pkg::data_t    item_operand,
	output logic              res_valid,
	input  logic              res_ready,
	output rpn_pkg::data_t    res_value,
	output rpn_pkg::depth_t   res_depth,
	output rpn_pkg::status_t  res_status
);
	import rpn_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	data_t           mem [STACK_DEPTH];
	action_t         action_q;
	data_t           operand_q;
	logic [CW-1:0]   count_q;
	data_t           rd_a_q;   // top (right operand)
	data_t           rd_b_q;   // second from top (left operand)
	data_t           mul_q;
	logic            out_valid_q;
	data_t           out_value_q;
	depth_t          out_depth_q;
	status_t         out_status_q;

	logic [CW-1:0]   cnt_m1;
	logic [AW-1:0]   cnt_m2;
	logic [CW-1:0]   cnt_next;
	data_t           prod;
	logic            cnt_zero;
	logic            cnt_few;
	logic            cnt_full;
	logic            rhs_zero;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	data_t           wr_data;
	data_t           value;
	data_t           top_or_zero;
	status_t         st;
	data_t           quotient;
	logic            div_done;

	assign cnt_m1   = count_q - CW'(1);
	assign cnt_m2   = count_q[AW-1:0] - AW'(2);
	assign cnt_zero = (count_q == '0);
	assign cnt_few  = (count_q < CW'(2));
	assign cnt_full = (count_q >= CW'(STACK_DEPTH));
	assign rhs_zero = (rd_a_q == '0);
	assign top_or_zero = cnt_zero ? '0 : rd_a_q;
	// only the low word of the product is kept
	assign prod     = rd_b_q * rd_a_q;

	rpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rd_b_q),
		.divisor  (rd_a_q),
		.quotient (quotient),
		.done     (div_done)
	);

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = cnt_m2;
		wr_data  = '0;
		cnt_next = count_q;
		value    = top_or_zero;
		st       = ST_OK;
		case (action_q)
			ACT_PUSH: begin
				if (cnt_full) begin
					st = ST_FULL;
				end else begin
					wr_en    = 1'b1;
					wr_addr  = count_q[AW-1:0];
					wr_data  = operand_q;
					cnt_next = count_q + CW'(1);
					value    = operand_q;
				end
			end
			ACT_POP: begin
				if (cnt_zero) begin
					st = ST_FEW;
				end else begin
					cnt_next = cnt_m1;
					value    = rd_a_q;
				end
			end
			ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
				if (cnt_few) begin
					st = ST_FEW;
				end else if (action_q == ACT_DIV && rhs_zero) begin
					st = ST_DIVZERO;
				end else begin
					case (action_q)
						ACT_ADD: wr_data = rd_b_q + rd_a_q;
						ACT_SUB: wr_data = rd_b_q - rd_a_q;
						ACT_MUL: wr_data = mul_q;
						default: wr_data = quotient;
					endcase
					wr_en    = 1'b1;
					cnt_next = cnt_m1;
					value    = wr_data;
				end
			end
			default: begin
				value = top_or_zero;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q  <= item_action;
			operand_q <= item_operand;
		end
		if (cmd.read) begin
			rd_a_q <= mem[cnt_m1[AW-1:0]];
			rd_b_q <= mem[cnt_m2];
		end
		mul_q <= prod;
		if (cmd.commit && wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.commit) begin
			out_value_q  <= value;
			out_depth_q  <= depth_t'(cnt_next);
			out_status_q <= st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				count_q     <= cnt_next;
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.need_div = (action_q == ACT_DIV) && !cnt_few && !rhs_zero;
	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || res_ready;

	assign res_valid  = out_valid_q;
	assign res_value  = out_value_q;
	assign res_depth  = out_depth_q;
	assign res_status = out_status_q;

endmodule

/* hw/rtl/rpn_ctrl.sv */
// Controller: sequences read, evaluate, divide and commit for one word at a time.
module rpn_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  rpn_pkg::dp_stat_t stat,
	output rpn_pkg::dp_cmd_t  cmd
);
	import rpn_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_READ   = 3'd1;
	localparam logic [2:0] S_EVAL   = 3'd2;
	localparam logic [2:0] S_DIV    = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		state_d       = state_q;
		cmd.load      = 1'b0;
		cmd.read      = 1'b0;
		cmd.div_start = 1'b0;
		cmd.commit    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_d  = S_EVAL;
			end
			S_EVAL: begin
				// product is registered on this edge, so multiply can commit next
				if (stat.need_div) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					state_d = S_COMMIT;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hw/rtl/rpn_stack_calculator.sv */
// RPN integer calculator: one word in, one result word out, over a bounded stack.
// Each accepted word steps through the read, evaluate and commit states; a divide adds
// a divide state for the bit-serial divider (one quotient bit per cycle) before commit.
// A new word is taken only after the previous one has committed, and commit waits while
// the output still holds an untaken result. A result waits in its own output register.
// Reset clears the entry count, controller and output valid; stack contents are not cleared.
module rpn_stack_calculator #(
	parameter int STACK_DEPTH = 16
) (
	input logic          clk,
	input logic          arst_n,
	rpn_item_if.sink     item,
	rpn_result_if.source result
);
	import rpn_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	rpn_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	rpn_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.item_action  (item.action),
		.item_operand (item.operand),
		.res_valid    (result.valid),
		.res_ready    (result.ready),
		.res_value    (result.result_value),
		.res_depth    (result.stack_depth),
		.res_status   (result.status)
	);

endmodule

/* tb/rpn_stack_calculator_tb.sv */
// Self-checking testbench for the RPN stack calculator: directed and random words, scoreboarded.
module rpn_stack_calculator_tb;
	import rpn_pkg::*;

	localparam int CALC_DEPTH  = 16;
	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_HOLD   = 300;
	localparam int DRAIN_WAIT  = 60;
	localparam int RAND_WORDS  = 1027;
	localparam int PAUSE_AT    = 500;

	// selector codes with no operation behind them
	localparam action_t ACT_SPARE6 = 3'd6;
	localparam action_t ACT_SPARE7 = 3'd7;

	typedef struct {
		data_t   value;
		depth_t  depth;
		status_t status;
	} calc_result_t;

	class calc_scoreboard;
		data_t        stack_mem[CALC_DEPTH];
		int           entries;
		int           errors;
		calc_result_t expected_q[$];

		function new();
			entries = 0;
			errors = 0;
			foreach (stack_mem[i]) stack_mem[i] = '0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function data_t top_value();
			return (entries == 0) ? '0 : stack_mem[entries-1];
		endfunction

		// signed divide, truncating toward zero; min / -1 wraps to min
		function data_t trunc_quot(data_t num, data_t den);
			data_t mag_n, mag_d, q;
			mag_n = num[DATA_W-1] ? -num : num;
			mag_d = den[DATA_W-1] ? -den : den;
			q = mag_n / mag_d;
			return (num[DATA_W-1] ^ den[DATA_W-1]) ? -q : q;
		endfunction

		function void note_word(action_t act, data_t opnd);
			calc_result_t want;
			data_t lhs, rhs, res;
			bit apply;
			want.status = ST_OK;
			res = '0;
			case (act)
				ACT_PUSH: begin
					if (entries >= CALC_DEPTH) begin
						want.status = ST_FULL;
					end else begin
						stack_mem[entries] = opnd;
						entries++;
					end
					want.value = top_value();
				end
				ACT_POP: begin
					if (entries == 0) begin
						want.status = ST_FEW;
						want.value = '0;
					end else begin
						entries--;
						want.value = stack_mem[entries];
					end
				end
				ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
					if (entries < 2) begin
						want.status = ST_FEW;
					end else begin
						rhs = stack_mem[entries-1];
						lhs = stack_mem[entries-2];
						apply = 1'b1;
						case (act)
							ACT_ADD: res = lhs + rhs;
							ACT_SUB: res = lhs - rhs;
							ACT_MUL: res = lhs * rhs;
							default: begin
								if (rhs == '0) begin
									want.status = ST_DIVZERO;
									apply = 1'b0;
								end else begin
									res = trunc_quot(lhs, rhs);
								end
							end
						endcase
						if (apply) begin
							entries--;
							stack_mem[entries-1] = res;
						end
					end
					want.value = top_value();
				end
				default: want.value = top_value();
			endcase
			want.depth = depth_t'(entries);
			expected_q.push_back(want);
		endfunction

		function void check_result(data_t value, depth_t depth, status_t status);
			calc_result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result word: value %h depth %0d status %0d",
					$time, value, depth, status);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (value !== want.value) begin
				$display("%0t: result_value mismatch: expected %h, got %h",
					$time, want.value, value);
				errors++;
			end
			if (depth !== want.depth) begin
				$display("%0t: stack_depth mismatch: expected %0d, got %0d",
					$time, want.depth, depth);
				errors++;
			end
			if (status !== want.status) begin
				$display("%0t: status mismatch: expected %0d, got %0d",
					$time, want.status, status);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rpn_item_if   item_ch();
	rpn_result_if result_ch();

	rpn_stack_calculator #(
		.STACK_DEPTH(CALC_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch)
	);

	calc_scoreboard sb = new();

	int results_seen = 0;
	int cycles = 0;
	int calm_left = 0;
	int fill_target = 4;
	bit long_hold_done = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic data_t pick_operand();
		int r;
		data_t v;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			v = $urandom_range(0, 20);
			return v - 10;
		end
		if (r < 40) begin
			case ($urandom_range(0, 4))
				0: return 32'h0000_0000;
				1: return 32'h0000_0001;
				2: return 32'hFFFF_FFFF;
				3: return 32'h7FFF_FFFF;
				default: return 32'h8000_0000;
			endcase
		end
		return $urandom();
	endfunction

	function automatic action_t op_by_index(int idx);
		case (idx)
			0: return ACT_PUSH;
			1: return ACT_ADD;
			2: return ACT_SUB;
			3: return ACT_MUL;
			4: return ACT_DIV;
			default: return ACT_POP;
		endcase
	endfunction

	// mostly well-formed RPN: climb to a target depth, then reduce; some noise
	task automatic pick_random_word(output action_t act, output data_t opnd);
		int r;
		r = $urandom_range(0, 99);
		opnd = pick_operand();
		if (sb.entries >= CALC_DEPTH && $urandom_range(0, 2) == 0)
			fill_target = $urandom_range(0, 4);
		if ($urandom_range(0, 39) == 0)
			fill_target = ($urandom_range(0, 3) == 0) ? CALC_DEPTH + 1 : $urandom_range(0, 6);
		if (r < 3) begin
			act = r[0] ? ACT_SPARE7 : ACT_SPARE6;
		end else if (r < 8) begin
			act = op_by_index($urandom_range(1, 5));
		end else if (sb.entries < fill_target || sb.entries < 2) begin
			act = ACT_PUSH;
		end else begin
			act = ($urandom_range(0, 99) < 25) ? ACT_PUSH : op_by_index($urandom_range(1, 5));
		end
	endtask

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic send_word(action_t act, data_t opnd);
		int gap;
		if (calm_left > 0) begin
			calm_left--;
			gap = 0;
		end else begin
			if ($urandom_range(0, 59) == 0) calm_left = 40;
			gap = pick_gap();
		end
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid   <= 1'b1;
		item_ch.action  <= act;
		item_ch.operand <= opnd;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_word(act, opnd);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			sb.check_result(result_ch.result_value, result_ch.stack_depth, result_ch.status);
			results_seen++;
		end
	end

	// result side backpressure, with one long hold-off to fill the block
	initial begin
		int hi, lo;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!long_hold_done && results_seen >= 300) begin
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_done = 1'b1;
			end
			hi = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
			result_ch.ready <= 1'b1;
			repeat (hi) @(negedge clk);
			lo = pick_gap();
			if (lo > 0) begin
				result_ch.ready <= 1'b0;
				repeat (lo) @(negedge clk);
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("rpn_stack_calculator_tb: FAIL");
		$finish;
	end

	initial begin
		action_t act;
		data_t opnd;
		arst_n = 1'b0;
		item_ch.valid   <= 1'b0;
		item_ch.action  <= ACT_PUSH;
		item_ch.operand <= '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty-stack and single-entry cases
		send_word(ACT_POP, '0);
		send_word(ACT_ADD, '0);
		send_word(ACT_SPARE6, 32'hFFFF_FFFF);
		send_word(ACT_PUSH, 32'h7FFF_FFFF);
		send_word(ACT_DIV, '0);
		// overflow wrap on add, then min / -1
		send_word(ACT_PUSH, 32'h0000_0001);
		send_word(ACT_ADD, '0);
		send_word(ACT_PUSH, 32'hFFFF_FFFF);
		send_word(ACT_DIV, '0);
		// divide by zero leaves the stack alone
		send_word(ACT_PUSH, 32'h0000_0000);
		send_word(ACT_DIV, '0);
		send_word(ACT_SPARE7, 32'h8000_0000);
		send_word(ACT_POP, '0);
		send_word(ACT_PUSH, 32'h8000_0000);
		send_word(ACT_ADD, '0);
		send_word(ACT_PUSH, 32'hFFFF_FFF9);
		send_word(ACT_SUB, '0);
		send_word(ACT_PUSH, 32'hFFFF_FFF9);
		send_word(ACT_PUSH, 32'h0000_0002);
		send_word(ACT_DIV, '0);
		send_word(ACT_MUL, '0);
		send_word(ACT_POP, '0);
		send_word(ACT_POP, '0);

		for (int n = 0; n < RAND_WORDS; n++) begin
			if (n == PAUSE_AT) begin
				item_ch.valid <= 1'b0;
				while (sb.pending() != 0) @(negedge clk);
				@(negedge clk);
			end
			pick_random_word(act, opnd);
			send_word(act, opnd);
		end
		item_ch.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("rpn_stack_calculator_tb: PASS");
		end else begin
			$display("rpn_stack_calculator_tb: FAIL");
		end
		$finish;
	end

endmodule
